[hw/rtl/cea_pkg.sv]
// ----------------------------------------------------------------------------
// cea_pkg
// Shared types, widths, stage indexes and helper functions of the complex
// element-wise ALU: CORDIC angle table, saturation and cell state records.
// ----------------------------------------------------------------------------
package cea_pkg;

   localparam int DATA_W   = 16;
   localparam int FRAC_W   = 12;
   localparam int CORDIC_N = 16;
   localparam int OP_W     = 4;

   localparam int GUARD_SH = 8;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int DEN_W    = PROD_W;
   localparam int QUO_W    = DATA_W + FRAC_W + 1;
   localparam int EARLY_W  = SUM_W + 1 - FRAC_W;
   localparam int CX_W     = DATA_W + GUARD_SH + 4;
   localparam int Z_W      = 34;
   localparam int SH_W     = 5;
   localparam int GAIN_W   = 23;
   localparam int PRD_W    = CX_W + GAIN_W;
   localparam int MAG_W    = PRD_W - 30;
   localparam int ANG_W    = Z_W - 30 + FRAC_W;
   localparam int WIDE_W   = 40;

   localparam int ST_IN    = 1;
   localparam int ST_COR   = 2;
   localparam int ST_CMUL  = ST_COR + CORDIC_N + 1;
   localparam int ST_CRES  = ST_CMUL + 1;
   localparam int ST_DIV0  = 4;
   localparam int ST_LAST  = ST_DIV0 + QUO_W;

   localparam logic [GAIN_W-1:0] GAIN_Q22 = GAIN_W'(2547003);
   localparam logic signed [Z_W-1:0] PI_Q30 = Z_W'(64'sd3373259426);
   localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1 << FRAC_W);
   localparam longint VMAX_L = (longint'(1) << (DATA_W - 1)) - 1;
   localparam logic signed [WIDE_W-1:0] VMAX = WIDE_W'(VMAX_L);
   localparam logic signed [WIDE_W-1:0] VMIN = WIDE_W'(-VMAX_L - 1);
   localparam logic signed [WIDE_W-1:0] BIG  = WIDE_W'(longint'(1) << (WIDE_W - 2));

   typedef enum logic [OP_W-1:0] {
      OP_ABS  = 4'd0,
      OP_NEG  = 4'd1,
      OP_INV  = 4'd2,
      OP_ADD  = 4'd3,
      OP_SUB  = 4'd4,
      OP_MUL  = 4'd5,
      OP_DIV  = 4'd6,
      OP_CONJ = 4'd7,
      OP_ARG  = 4'd8
   } op_type;

   typedef struct packed {
      logic   vld;
      op_type op;
      logic   azero;
   } ctl_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cvec_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] low;
      logic [QUO_W-1:0] quo;
      logic [DEN_W-1:0] den;
   } dstate_type;

   typedef struct packed {
      logic neg_re;
      logic neg_im;
      logic ovf_re;
      logic ovf_im;
      logic dz;
   } divf_type;

   typedef struct packed {
      logic signed [EARLY_W-1:0] re;
      logic signed [EARLY_W-1:0] im;
   } early_type;

   typedef struct packed {
      logic [MAG_W-1:0]        mag;
      logic signed [ANG_W-1:0] ang;
   } cor_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     clip;
   } sat_type;

   function automatic logic signed [Z_W-1:0] atan_q30(input logic [SH_W-1:0] i);
      logic [31:0] t;
      case (i)
         5'd0:  t = 32'h3243F6A8;
         5'd1:  t = 32'h1DAC6705;
         5'd2:  t = 32'h0FADBAFC;
         5'd3:  t = 32'h07F56EA6;
         5'd4:  t = 32'h03FEAB76;
         5'd5:  t = 32'h01FFD55B;
         5'd6:  t = 32'h00FFFAAA;
         5'd7:  t = 32'h007FFF55;
         5'd8:  t = 32'h003FFFEA;
         5'd9:  t = 32'h001FFFFD;
         5'd10: t = 32'h000FFFFF;
         5'd11: t = 32'h0007FFFF;
         5'd12: t = 32'h0003FFFF;
         5'd13: t = 32'h0001FFFF;
         5'd14: t = 32'h0000FFFF;
         5'd15: t = 32'h00007FFF;
         5'd16: t = 32'h00003FFF;
         5'd17: t = 32'h00001FFF;
         5'd18: t = 32'h00000FFF;
         5'd19: t = 32'h000007FF;
         5'd20: t = 32'h000003FF;
         5'd21: t = 32'h000001FF;
         5'd22: t = 32'h000000FF;
         5'd23: t = 32'h0000007F;
         5'd24: t = 32'h0000003F;
         5'd25: t = 32'h0000001F;
         5'd26: t = 32'h0000000F;
         5'd27: t = 32'h00000008;
         5'd28: t = 32'h00000004;
         5'd29: t = 32'h00000002;
         5'd30: t = 32'h00000001;
         default: t = 32'h00000000;
      endcase
      return signed'(Z_W'(t));
   endfunction

   function automatic sat_type sat_data(input logic signed [WIDE_W-1:0] v);
      sat_type s;
      if (v > VMAX) begin
         s.val  = VMAX[DATA_W-1:0];
         s.clip = 1'b1;
      end else if (v < VMIN) begin
         s.val  = VMIN[DATA_W-1:0];
         s.clip = 1'b1;
      end else begin
         s.val  = v[DATA_W-1:0];
         s.clip = 1'b0;
      end
      return s;
   endfunction

endpackage

[hw/rtl/cea_cordic_cell.sv]
// ----------------------------------------------------------------------------
// cea_cordic_cell
// One vectoring CORDIC micro-rotation, registered; the shift is the cell's
// position in the chain.
// ----------------------------------------------------------------------------
module cea_cordic_cell (
   input  logic                       clock,
   input  logic [cea_pkg::SH_W-1:0]   shift,
   input  cea_pkg::cvec_type          vin,
   output cea_pkg::cvec_type          vout
);
   import cea_pkg::*;

   cvec_type               vec_ff;
   cvec_type               vec_in;
   logic signed [CX_W-1:0] xs;
   logic signed [CX_W-1:0] ys;

   always_comb begin
      xs = vin.x >>> shift;
      ys = vin.y >>> shift;
      if (!vin.y[CX_W-1]) begin
         vec_in.x = vin.x + ys;
         vec_in.y = vin.y - xs;
         vec_in.z = vin.z + atan_q30(shift);
      end else begin
         vec_in.x = vin.x - ys;
         vec_in.y = vin.y + xs;
         vec_in.z = vin.z - atan_q30(shift);
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   assign vout = vec_ff;

endmodule

[hw/rtl/cea_div_cell.sv]
// ----------------------------------------------------------------------------
// cea_div_cell
// One restoring division step, registered: shift in the next dividend bit,
// trial-subtract the divisor and append one quotient bit.
// ----------------------------------------------------------------------------
module cea_div_cell (
   input  logic                 clock,
   input  cea_pkg::dstate_type  din,
   output cea_pkg::dstate_type  dout
);
   import cea_pkg::*;

   dstate_type       st_ff;
   dstate_type       st_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      trial     = {din.rem, din.low[QUO_W-1]};
      diff      = trial - {1'b0, din.den};
      ge        = trial >= {1'b0, din.den};
      st_in.rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      st_in.low = {din.low[QUO_W-2:0], 1'b0};
      st_in.quo = {din.quo[QUO_W-2:0], ge};
      st_in.den = din.den;
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   assign dout = st_ff;

endmodule

[hw/rtl/complex_elementwise_alu_core.sv]
// ----------------------------------------------------------------------------
// complex_elementwise_alu_core
// Element-wise complex ALU on Q3.12 operands: abs, neg, inv, add, sub, mul,
// div, conj and arg, with saturation and divide-by-zero flags.
//
//   channel   ports                         transfer
//   input     start, busy, req_*            start high while busy low
//   result    rsp_strobe, rsp_*             rsp_strobe high, one cycle
//
// One item may start in every cycle; busy is tied low.
// Each result passes the input, product, sum and divider setup registers,
// the 29-cell divider chain and the output register. CORDIC for abs and arg
// runs through 16 cells and is delayed to match.
// Reset clears the valid bits of the pipeline; the receiver cannot stall.
// ----------------------------------------------------------------------------
module complex_elementwise_alu_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [cea_pkg::OP_W-1:0]           req_operation,
   input  logic signed [cea_pkg::DATA_W-1:0]  req_a_real,
   input  logic signed [cea_pkg::DATA_W-1:0]  req_a_imag,
   input  logic signed [cea_pkg::DATA_W-1:0]  req_b_real,
   input  logic signed [cea_pkg::DATA_W-1:0]  req_b_imag,
   output logic                               rsp_strobe,
   output logic signed [cea_pkg::DATA_W-1:0]  rsp_result_real,
   output logic signed [cea_pkg::DATA_W-1:0]  rsp_result_imag,
   output logic                               rsp_saturated,
   output logic                               rsp_divide_by_zero
);
   import cea_pkg::*;

   ctl_type                   ctl_ff [ST_IN:ST_LAST];
   logic signed [DATA_W-1:0]  ar_ff, ai_ff, br_ff, bi_ff;

   logic signed [DATA_W-1:0]  nr, ni, dr, di;
   logic signed [DATA_W:0]    ae, be, ce, de;
   logic signed [PROD_W-1:0]  pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   early_type                 simp_in, simp_ff, simp_d_ff;
   cvec_type                  cinit_in, cinit_ff;
   logic signed [DATA_W:0]    xa, ya;

   logic signed [SUM_W-1:0]   s_aab_ff, s_asb_ff, s_cad_ff, s_csd_ff;
   logic [DEN_W-1:0]          den_ff;

   logic [DEN_W-1:0]          n_re, n_im;
   logic signed [SUM_W-1:0]   m_re, m_im;
   logic signed [SUM_W:0]     r_re, r_im;
   dstate_type                dinit_re_in, dinit_im_in;
   dstate_type                dinit_re_ff, dinit_im_ff;
   early_type                 early_in;
   divf_type                  divf_in;
   early_type                 early_ff [ST_DIV0:ST_LAST];
   divf_type                  divf_ff [ST_DIV0:ST_LAST];

   dstate_type                dst_re [0:QUO_W];
   dstate_type                dst_im [0:QUO_W];
   cvec_type                  cvec [0:CORDIC_N];

   logic [PRD_W-1:0]          cmul_ff;
   logic signed [Z_W-1:0]     cz_ff;
   logic [PRD_W-1:0]          cmul_rnd;
   logic signed [Z_W-1:0]     cz_rnd;
   cor_type                   cres_in;
   cor_type                   cor_ff [ST_CRES:ST_LAST];

   logic [QUO_W:0]            q_re1, q_im1;
   logic signed [WIDE_W-1:0]  qv_re, qv_im, dv_re, dv_im;
   logic signed [WIDE_W-1:0]  o_re, o_im;
   sat_type                   sat_re, sat_im;
   ctl_type                   ctl_last;
   divf_type                  divf_last;
   logic                      dz_in;

   logic                      rsp_strobe_ff, rsp_sat_ff, rsp_dz_ff;
   logic signed [DATA_W-1:0]  rsp_re_ff, rsp_im_ff;

   assign busy = 1'b0;

   // control shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = ST_IN; k <= ST_LAST; k++) begin
            ctl_ff[k].vld <= 1'b0;
         end
      end else begin
         ctl_ff[ST_IN].vld   <= start & ~busy;
         ctl_ff[ST_IN].op    <= op_type'(req_operation);
         ctl_ff[ST_IN].azero <= (req_a_real == '0) && (req_a_imag == '0);
         for (int k = ST_IN + 1; k <= ST_LAST; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      ar_ff <= req_a_real;
      ai_ff <= req_a_imag;
      br_ff <= req_b_real;
      bi_ff <= req_b_imag;
   end

   // operand select, products, simple ops, CORDIC start
   always_comb begin
      if (ctl_ff[ST_IN].op == OP_INV) begin
         nr = ONE_Q;
         ni = '0;
         dr = ar_ff;
         di = ai_ff;
      end else begin
         nr = ar_ff;
         ni = ai_ff;
         dr = br_ff;
         di = bi_ff;
      end
      ae = (DATA_W+1)'(ar_ff);
      be = (DATA_W+1)'(ai_ff);
      ce = (DATA_W+1)'(br_ff);
      de = (DATA_W+1)'(bi_ff);
      case (ctl_ff[ST_IN].op)
         OP_NEG: begin
            simp_in.re = EARLY_W'(-ae);
            simp_in.im = EARLY_W'(-be);
         end
         OP_ADD: begin
            simp_in.re = EARLY_W'(ae + ce);
            simp_in.im = EARLY_W'(be + de);
         end
         OP_SUB: begin
            simp_in.re = EARLY_W'(ae - ce);
            simp_in.im = EARLY_W'(be - de);
         end
         OP_CONJ: begin
            simp_in.re = EARLY_W'(ae);
            simp_in.im = EARLY_W'(-be);
         end
         default: begin
            simp_in.re = '0;
            simp_in.im = '0;
         end
      endcase
      xa = ar_ff[DATA_W-1] ? -ae : ae;
      ya = ar_ff[DATA_W-1] ? -be : be;
      cinit_in.x = CX_W'(xa) <<< GUARD_SH;
      cinit_in.y = CX_W'(ya) <<< GUARD_SH;
      if (ar_ff[DATA_W-1]) begin
         cinit_in.z = ai_ff[DATA_W-1] ? -PI_Q30 : PI_Q30;
      end else begin
         cinit_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff    <= nr * dr;
      pb_ff    <= ni * di;
      pc_ff    <= ni * dr;
      pd_ff    <= nr * di;
      pe_ff    <= dr * dr;
      pf_ff    <= di * di;
      simp_ff  <= simp_in;
      cinit_ff <= cinit_in;
   end

   // sums
   always_ff @(posedge clock) begin
      s_aab_ff  <= SUM_W'(pa_ff) + SUM_W'(pb_ff);
      s_asb_ff  <= SUM_W'(pa_ff) - SUM_W'(pb_ff);
      s_cad_ff  <= SUM_W'(pc_ff) + SUM_W'(pd_ff);
      s_csd_ff  <= SUM_W'(pc_ff) - SUM_W'(pd_ff);
      den_ff    <= DEN_W'($unsigned(pe_ff)) + DEN_W'($unsigned(pf_ff));
      simp_d_ff <= simp_ff;
   end

   // divider setup and multiply rounding
   always_comb begin
      m_re = s_aab_ff[SUM_W-1] ? -s_aab_ff : s_aab_ff;
      m_im = s_csd_ff[SUM_W-1] ? -s_csd_ff : s_csd_ff;
      n_re = m_re[DEN_W-1:0];
      n_im = m_im[DEN_W-1:0];
      dinit_re_in.rem = DEN_W'(n_re >> DATA_W);
      dinit_re_in.low = {n_re[DATA_W-1:0], (FRAC_W+1)'(0)};
      dinit_re_in.quo = '0;
      dinit_re_in.den = den_ff;
      dinit_im_in.rem = DEN_W'(n_im >> DATA_W);
      dinit_im_in.low = {n_im[DATA_W-1:0], (FRAC_W+1)'(0)};
      dinit_im_in.quo = '0;
      dinit_im_in.den = den_ff;
      divf_in.neg_re = s_aab_ff[SUM_W-1];
      divf_in.neg_im = s_csd_ff[SUM_W-1];
      divf_in.ovf_re = {DATA_W'(0), n_re} >= {den_ff, DATA_W'(0)};
      divf_in.ovf_im = {DATA_W'(0), n_im} >= {den_ff, DATA_W'(0)};
      divf_in.dz     = den_ff == '0;
      r_re = (SUM_W+1)'(s_asb_ff) + (SUM_W+1)'(1 << (FRAC_W - 1));
      r_im = (SUM_W+1)'(s_cad_ff) + (SUM_W+1)'(1 << (FRAC_W - 1));
      if (ctl_ff[ST_DIV0-1].op == OP_MUL) begin
         early_in.re = r_re[SUM_W:FRAC_W];
         early_in.im = r_im[SUM_W:FRAC_W];
      end else begin
         early_in = simp_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      dinit_re_ff       <= dinit_re_in;
      dinit_im_ff       <= dinit_im_in;
      early_ff[ST_DIV0] <= early_in;
      divf_ff[ST_DIV0]  <= divf_in;
      for (int k = ST_DIV0 + 1; k <= ST_LAST; k++) begin
         early_ff[k] <= early_ff[k-1];
         divf_ff[k]  <= divf_ff[k-1];
      end
   end

   // divider chains
   assign dst_re[0] = dinit_re_ff;
   assign dst_im[0] = dinit_im_ff;

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      cea_div_cell u_div_re (
         .clock (clock),
         .din   (dst_re[g]),
         .dout  (dst_re[g+1])
      );
      cea_div_cell u_div_im (
         .clock (clock),
         .din   (dst_im[g]),
         .dout  (dst_im[g+1])
      );
   end

   // CORDIC chain
   assign cvec[0] = cinit_ff;

   for (genvar g = 0; g < CORDIC_N; g++) begin : g_cor
      cea_cordic_cell u_cell (
         .clock (clock),
         .shift (SH_W'(g)),
         .vin   (cvec[g]),
         .vout  (cvec[g+1])
      );
   end

   always_comb begin
      cmul_rnd    = cmul_ff + PRD_W'(longint'(1) << 29);
      cz_rnd      = cz_ff + Z_W'(1 << (29 - FRAC_W));
      cres_in.mag = cmul_rnd[PRD_W-1:30];
      cres_in.ang = cz_rnd[Z_W-1:30-FRAC_W];
   end

   always_ff @(posedge clock) begin
      cmul_ff         <= PRD_W'($unsigned(cvec[CORDIC_N].x)) * PRD_W'(GAIN_Q22);
      cz_ff           <= cvec[CORDIC_N].z;
      cor_ff[ST_CRES] <= cres_in;
      for (int k = ST_CRES + 1; k <= ST_LAST; k++) begin
         cor_ff[k] <= cor_ff[k-1];
      end
   end

   // final select and saturation
   always_comb begin
      ctl_last  = ctl_ff[ST_LAST];
      divf_last = divf_ff[ST_LAST];
      q_re1 = {1'b0, dst_re[QUO_W].quo} + (QUO_W+1)'(1);
      q_im1 = {1'b0, dst_im[QUO_W].quo} + (QUO_W+1)'(1);
      qv_re = signed'(WIDE_W'(q_re1[QUO_W:1]));
      qv_im = signed'(WIDE_W'(q_im1[QUO_W:1]));
      if (divf_last.ovf_re) begin
         dv_re = divf_last.neg_re ? -BIG : BIG;
      end else begin
         dv_re = divf_last.neg_re ? -qv_re : qv_re;
      end
      if (divf_last.ovf_im) begin
         dv_im = divf_last.neg_im ? -BIG : BIG;
      end else begin
         dv_im = divf_last.neg_im ? -qv_im : qv_im;
      end
      dz_in = 1'b0;
      case (ctl_last.op)
         OP_ABS: begin
            o_re = signed'(WIDE_W'(cor_ff[ST_LAST].mag));
            o_im = '0;
         end
         OP_ARG: begin
            o_re = ctl_last.azero ? '0 : WIDE_W'(cor_ff[ST_LAST].ang);
            o_im = '0;
         end
         OP_INV, OP_DIV: begin
            dz_in = divf_last.dz;
            o_re  = divf_last.dz ? '0 : dv_re;
            o_im  = divf_last.dz ? '0 : dv_im;
         end
         OP_NEG, OP_ADD, OP_SUB, OP_MUL, OP_CONJ: begin
            o_re = WIDE_W'(early_ff[ST_LAST].re);
            o_im = WIDE_W'(early_ff[ST_LAST].im);
         end
         default: begin
            o_re = '0;
            o_im = '0;
         end
      endcase
      sat_re = sat_data(o_re);
      sat_im = sat_data(o_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         rsp_sat_ff    <= 1'b0;
         rsp_dz_ff     <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl_last.vld;
         rsp_sat_ff    <= ctl_last.vld & (sat_re.clip | sat_im.clip);
         rsp_dz_ff     <= ctl_last.vld & dz_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_re_ff <= sat_re.val;
      rsp_im_ff <= sat_im.val;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_result_real    = rsp_re_ff;
   assign rsp_result_imag    = rsp_im_ff;
   assign rsp_saturated      = rsp_sat_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

`ifndef SYNTHESIS
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[ST_LAST].vld |=> rsp_strobe)
      else $error("result strobe missing");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !ctl_ff[ST_LAST].vld |=> !rsp_strobe && !rsp_saturated && !rsp_divide_by_zero)
      else $error("result strobe or flag without item");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_divide_by_zero |-> rsp_result_real == '0 && rsp_result_imag == '0
                             && !rsp_saturated)
      else $error("divide by zero with nonzero result");

   a_real_only: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[ST_LAST].vld && (ctl_ff[ST_LAST].op == OP_ABS || ctl_ff[ST_LAST].op == OP_ARG)
      |=> rsp_result_imag == '0)
      else $error("imaginary part set on real-only result");

   a_dz_flag: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[ST_LAST].vld && divf_ff[ST_LAST].dz
      && (ctl_ff[ST_LAST].op == OP_INV || ctl_ff[ST_LAST].op == OP_DIV)
      |=> rsp_divide_by_zero)
      else $error("zero divisor not flagged");
`endif

endmodule
